// ===== src/csc_pkg.sv =====
`default_nettype none

package csc_pkg;

    // Largest grid size that the block honors; larger register values are clamped.
    localparam int unsigned MAX_GRID_POINTS = 128;

    // Configuration register indexes.
    localparam logic [1:0] REG_GRID_POINTS = 2'd0;
    localparam logic [1:0] REG_RADIUS      = 2'd1;
    localparam logic [1:0] REG_BLEND       = 2'd2;

    // Face codes.
    localparam logic [2:0] FACE_BASE  = 3'd0;
    localparam logic [2:0] FACE_ROT_1 = 3'd1;
    localparam logic [2:0] FACE_ROT_2 = 3'd2;
    localparam logic [2:0] FACE_ROT_3 = 3'd3;
    localparam logic [2:0] FACE_ROT_4 = 3'd4;
    localparam logic [2:0] FACE_ROT_5 = 3'd5;

    // Corner slots of a cell.
    localparam logic [2:0] SLOT_FIRST = 3'd0;
    localparam logic [2:0] SLOT_LAST  = 3'd5;

    // Row and column offsets of the grid point used by each slot, slot 0 in bit 0.
    localparam logic [5:0] ROW_STEP = 6'b110100;
    localparam logic [5:0] COL_STEP = 6'b011010;

    // One cell as it travels from the front to the back.
    typedef struct packed {
        logic [2:0] face;
        logic [6:0] row;
        logic [6:0] col;
    } cell_t;

    // Grid size as used by the arithmetic: at least 2, at most MAX_GRID_POINTS.
    function automatic logic [7:0] clamp_grid(input logic [7:0] gp);
        logic [7:0] n;
        if (gp < 8'd2)
        begin
            n = 8'd2;
        end
        else if (gp > 8'(MAX_GRID_POINTS))
        begin
            n = 8'(MAX_GRID_POINTS);
        end
        else
        begin
            n = gp;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== src/cube_sphere_cell_vertices_core.sv =====
// Spherified cube cell vertex generator.
// Input stream (s_*): one item names a cell: face in tuser, row and column in tdata.
// Output stream (m_*): six vertices per cell, slot number in tuser, tlast on slot five.
// Configuration: cfg_we writes register cfg_index (0 grid points, 1 radius, 2 blend)
// with cfg_wdata at a rising edge; write only while the block is idle.
// Input items pass through a clamp stage into a two-entry cell queue, so the input
// side keeps taking cells while the vertex engine works.
// Each vertex runs through the engine in turn: two 17-step grid dividers, a 17-step
// square root, a 17-step reciprocal divider and eight single states for setup, the
// multiplies and the output.
// The output register holds a vertex while m_tready is low; the engine finishes the
// next vertex and then waits, and the queue fills and drops s_tready.
// Reset clears the queue and the output valid and loads grid points 16, radius 1.0
// and full blend toward the sphere.
`default_nettype none

module cube_sphere_cell_vertices_core
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [15:0]    s_tdata,   // cell_row[6:0], cell_col[13:7], zero pad
    input  wire logic [2:0]     s_tuser,   // face[2:0]
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [47:0]         m_tdata,   // vertex_x[15:0], vertex_y[31:16], vertex_z[47:32]
    output logic [2:0]          m_tuser,   // corner_slot[2:0]
    output logic                m_tlast,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [16:0]    cfg_wdata
);

    logic [7:0]     grid_points_reg;
    logic [14:0]    radius_reg;
    logic [16:0]    blend_reg;
    logic           q_full;
    logic           q_empty;
    logic           push;
    logic           pop;
    csc_pkg::cell_t push_cell;
    csc_pkg::cell_t q_head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_points_reg <= 8'd16;
            radius_reg      <= 15'd256;
            blend_reg       <= 17'h10000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                csc_pkg::REG_GRID_POINTS: grid_points_reg <= cfg_wdata[7:0];
                csc_pkg::REG_RADIUS:      radius_reg      <= cfg_wdata[14:0];
                csc_pkg::REG_BLEND:       blend_reg       <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    csc_front u_front
    (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .grid_points (grid_points_reg),
        .q_full      (q_full),
        .push        (push),
        .push_cell   (push_cell)
    );

    csc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cell (push_cell),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    csc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .grid_points (grid_points_reg),
        .radius_q8   (radius_reg),
        .blend_q16   (blend_reg),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// ===== src/csc_front.sv =====
`default_nettype none

module csc_front
(
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [15:0]         s_tdata,   // cell_row[6:0], cell_col[13:7], zero pad
    input  wire logic [2:0]          s_tuser,   // face[2:0]
    input  wire logic [7:0]          grid_points,
    input  wire logic                q_full,
    output logic                     push,
    output csc_pkg::cell_t           push_cell
);

    logic [7:0] n_eff;
    logic [6:0] max_cell;
    logic [6:0] row_in;
    logic [6:0] col_in;

    // Take an item whenever the queue has room.
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Clamp the cell indexes to the last cell of the grid.
    assign n_eff    = csc_pkg::clamp_grid(grid_points);
    assign max_cell = 7'(n_eff - 8'd2);
    assign row_in   = s_tdata[6:0];
    assign col_in   = s_tdata[13:7];

    always_comb
    begin
        push_cell.row = (row_in > max_cell) ? max_cell : row_in;
        push_cell.col = (col_in > max_cell) ? max_cell : col_in;
        // Face codes six and seven fall back to the base face.
        push_cell.face = (s_tuser > csc_pkg::FACE_ROT_5) ? csc_pkg::FACE_BASE : s_tuser;
    end

endmodule

`default_nettype wire

// ===== src/csc_queue.sv =====
`default_nettype none

module csc_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire csc_pkg::cell_t push_cell,
    input  wire logic           pop,
    output logic                full,
    output logic                empty,
    output csc_pkg::cell_t      head
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    csc_pkg::cell_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [PTR_W:0]         count_reg;
    logic [PTR_W:0]         count_next;

    assign full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = (PTR_W+1)'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = (PTR_W+1)'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cell;
        end
    end

endmodule

`default_nettype wire

// ===== src/csc_back.sv =====
`default_nettype none

module csc_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [7:0]     grid_points,
    input  wire logic [14:0]    radius_q8,
    input  wire logic [16:0]    blend_q16,
    input  wire logic           q_empty,
    input  wire csc_pkg::cell_t q_head,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [47:0]         m_tdata,   // vertex_x[15:0], vertex_y[31:16], vertex_z[47:32]
    output logic [2:0]          m_tuser,   // corner_slot[2:0]
    output logic                m_tlast
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_DIV_U = 4'd2;
    localparam logic [3:0] ST_DIV_W = 4'd3;
    localparam logic [3:0] ST_SQ    = 4'd4;
    localparam logic [3:0] ST_SQRT  = 4'd5;
    localparam logic [3:0] ST_RECIP = 4'd6;
    localparam logic [3:0] ST_MUL_F = 4'd7;
    localparam logic [3:0] ST_SUM_F = 4'd8;
    localparam logic [3:0] ST_MUL_T = 4'd9;
    localparam logic [3:0] ST_MUL_X = 4'd10;
    localparam logic [3:0] ST_MUL_Y = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    // Every serial unit produces 17 result bits, one per cycle.
    localparam logic [4:0] LAST_STEP = 5'd16;

    logic [3:0]     state_reg, state_next;
    csc_pkg::cell_t cell_reg, cell_next;
    logic [2:0]     slot_reg, slot_next;
    logic [4:0]     cnt_reg, cnt_next;

    logic [16:0]    gnum_reg, gnum_next;
    logic [6:0]     grem_reg, grem_next;
    logic           u_neg_reg, u_neg_next;
    logic [8:0]     u_mag_reg, u_mag_next;
    logic           w_neg_reg, w_neg_next;
    logic [8:0]     w_mag_reg, w_mag_next;
    logic [33:0]    sqs_reg, sqs_next;
    logic [19:0]    srem_reg, srem_next;
    logic [16:0]    sroot_reg, sroot_next;
    logic [16:0]    len_reg, len_next;
    logic [16:0]    rnum_reg, rnum_next;
    logic [16:0]    rrem_reg, rrem_next;
    logic [33:0]    bf_reg, bf_next;
    logic [16:0]    f_reg, f_next;
    logic [31:0]    t_reg, t_next;
    logic [40:0]    px_reg, px_next;
    logic [40:0]    py_reg, py_next;

    logic           m_valid_reg, m_valid_next;
    logic [47:0]    m_data_reg, m_data_next;
    logic [2:0]     m_slot_reg, m_slot_next;
    logic           m_last_reg, m_last_next;

    logic [7:0]     n_eff;
    logic [6:0]     div_d;
    logic [6:0]     k_cur;
    logic [6:0]     m_cur;
    logic [7:0]     gtrial;
    logic           gge;
    logic [6:0]     grem_step;
    logic [16:0]    gnum_step;
    logic [19:0]    srem_sh;
    logic [19:0]    strial;
    logic           sge;
    logic [17:0]    rtrial;
    logic           rge;
    logic [16:0]    blend_eff;
    logic [17:0]    sq_sum;
    logic [33:0]    f_sum;
    logic [15:0]    vx, vy, vz;
    logic [15:0]    ox, oy, oz;
    logic           out_free;

    // Magnitude and sign of a grid coordinate from the divider quotient.
    function automatic logic [9:0] grid_mag(input logic [16:0] q);
        logic [9:0] r;
        if (q[9:0] >= 10'd256)
        begin
            r = {1'b0, 9'(q[9:0] - 10'd256)};
        end
        else
        begin
            r = {1'b1, 9'(10'd256 - q[9:0])};
        end
        return r;
    endfunction

    // Round a scaled magnitude back to Q8.8, saturate and apply the sign.
    function automatic logic [15:0] scale_out(input logic [40:0] prod, input logic neg);
        logic [41:0] sum;
        logic [16:0] v;
        logic [16:0] mag;
        sum = {1'b0, prod} + 42'h800000;
        v   = sum[40:24];
        if (neg)
        begin
            mag = (v > 17'd32768) ? 17'd32768 : v;
            return 16'(17'd0 - mag);
        end
        else
        begin
            mag = (v > 17'd32767) ? 17'd32767 : v;
            return mag[15:0];
        end
    endfunction

    // Numerator of the grid coordinate division: 512k + floor(d/2).
    function automatic logic [16:0] grid_num(input logic [6:0] k, input logic [6:0] d);
        return 17'({k, 9'b0}) + 17'(d >> 1);
    endfunction

    assign n_eff     = csc_pkg::clamp_grid(grid_points);
    assign div_d     = 7'(n_eff - 8'd1);
    assign k_cur     = 7'(cell_reg.row + 7'(csc_pkg::ROW_STEP[slot_reg]));
    assign m_cur     = 7'(cell_reg.col + 7'(csc_pkg::COL_STEP[slot_reg]));
    assign blend_eff = (blend_q16 > 17'h10000) ? 17'h10000 : blend_q16;

    // One restoring step of the grid coordinate divider.
    assign gtrial    = {grem_reg, gnum_reg[16]};
    assign gge       = (gtrial >= {1'b0, div_d});
    assign grem_step = gge ? 7'(gtrial - {1'b0, div_d}) : gtrial[6:0];
    assign gnum_step = {gnum_reg[15:0], gge};

    // One digit of the square root.
    assign srem_sh = {srem_reg[17:0], sqs_reg[33:32]};
    assign strial  = {1'b0, sroot_reg, 2'b01};
    assign sge     = (srem_sh >= strial);

    // One restoring step of the reciprocal divider.
    assign rtrial = {rrem_reg, rnum_reg[16]};
    assign rge    = (rtrial >= {1'b0, len_reg});

    // Squared length of the cube point in Q2.16 before the final shift.
    assign sq_sum = 18'(u_mag_reg * u_mag_reg) + 18'(w_mag_reg * w_mag_reg) + 18'h10000;

    // Blend between the inverse length and one.
    assign f_sum = bf_reg + 34'({17'h10000 - blend_eff, 16'b0}) + 34'd32768;

    // Rounded coordinates and face permutation.
    assign vx = scale_out(px_reg, u_neg_reg);
    assign vy = scale_out(py_reg, w_neg_reg);
    assign vz = scale_out({1'b0, t_reg, 8'b0}, 1'b0);

    always_comb
    begin
        unique case (cell_reg.face)
            csc_pkg::FACE_ROT_1:
            begin
                ox = 16'd0 - vz; oy = vy; oz = vx;
            end
            csc_pkg::FACE_ROT_2:
            begin
                ox = 16'd0 - vx; oy = vy; oz = 16'd0 - vz;
            end
            csc_pkg::FACE_ROT_3:
            begin
                ox = vz; oy = vy; oz = 16'd0 - vx;
            end
            csc_pkg::FACE_ROT_4:
            begin
                ox = vx; oy = vz; oz = 16'd0 - vy;
            end
            csc_pkg::FACE_ROT_5:
            begin
                ox = vx; oy = 16'd0 - vz; oz = vy;
            end
            default:
            begin
                ox = vx; oy = vy; oz = vz;
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_tready;

    // Sequencer: each slot runs the dividers, the root and the multiplies in turn.
    always_comb
    begin
        state_next   = state_reg;
        cell_next    = cell_reg;
        slot_next    = slot_reg;
        cnt_next     = cnt_reg;
        gnum_next    = gnum_reg;
        grem_next    = grem_reg;
        u_neg_next   = u_neg_reg;
        u_mag_next   = u_mag_reg;
        w_neg_next   = w_neg_reg;
        w_mag_next   = w_mag_reg;
        sqs_next     = sqs_reg;
        srem_next    = srem_reg;
        sroot_next   = sroot_reg;
        len_next     = len_reg;
        rnum_next    = rnum_reg;
        rrem_next    = rrem_reg;
        bf_next      = bf_reg;
        f_next       = f_reg;
        t_next       = t_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pop          = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_slot_next  = m_slot_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    cell_next  = q_head;
                    slot_next  = csc_pkg::SLOT_FIRST;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                gnum_next  = grid_num(k_cur, div_d);
                grem_next  = '0;
                cnt_next   = '0;
                state_next = ST_DIV_U;
            end
            ST_DIV_U:
            begin
                gnum_next = gnum_step;
                grem_next = grem_step;
                cnt_next  = 5'(cnt_reg + 1'b1);
                if (cnt_reg == LAST_STEP)
                begin
                    {u_neg_next, u_mag_next} = grid_mag(gnum_step);
                    gnum_next  = grid_num(m_cur, div_d);
                    grem_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV_W;
                end
            end
            ST_DIV_W:
            begin
                gnum_next = gnum_step;
                grem_next = grem_step;
                cnt_next  = 5'(cnt_reg + 1'b1);
                if (cnt_reg == LAST_STEP)
                begin
                    {w_neg_next, w_mag_next} = grid_mag(gnum_step);
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                sqs_next   = {sq_sum, 16'b0};
                srem_next  = '0;
                sroot_next = '0;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                sqs_next   = {sqs_reg[31:0], 2'b00};
                srem_next  = sge ? 20'(srem_sh - strial) : srem_sh;
                sroot_next = {sroot_reg[15:0], sge};
                cnt_next   = 5'(cnt_reg + 1'b1);
                if (cnt_reg == LAST_STEP)
                begin
                    // Numerator 2^32 + floor(L/2): its top bits seed the remainder.
                    len_next   = {sroot_reg[15:0], sge};
                    rrem_next  = 17'h08000;
                    rnum_next  = {1'b0, sroot_reg[15:0]};
                    cnt_next   = '0;
                    state_next = ST_RECIP;
                end
            end
            ST_RECIP:
            begin
                rrem_next = rge ? 17'(rtrial - {1'b0, len_reg}) : rtrial[16:0];
                rnum_next = {rnum_reg[15:0], rge};
                cnt_next  = 5'(cnt_reg + 1'b1);
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_MUL_F;
                end
            end
            ST_MUL_F:
            begin
                bf_next    = blend_eff * rnum_reg;
                state_next = ST_SUM_F;
            end
            ST_SUM_F:
            begin
                f_next     = f_sum[32:16];
                state_next = ST_MUL_T;
            end
            ST_MUL_T:
            begin
                t_next     = f_reg * radius_q8;
                state_next = ST_MUL_X;
            end
            ST_MUL_X:
            begin
                px_next    = u_mag_reg * t_reg;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                py_next    = w_mag_reg * t_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {oz, oy, ox};
                    m_slot_next  = slot_reg;
                    m_last_next  = (slot_reg == csc_pkg::SLOT_LAST);
                    if (slot_reg == csc_pkg::SLOT_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        slot_next  = 3'(slot_reg + 1'b1);
                        state_next = ST_START;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            slot_reg    <= csc_pkg::SLOT_FIRST;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cell_reg   <= cell_next;
        gnum_reg   <= gnum_next;
        grem_reg   <= grem_next;
        u_neg_reg  <= u_neg_next;
        u_mag_reg  <= u_mag_next;
        w_neg_reg  <= w_neg_next;
        w_mag_reg  <= w_mag_next;
        sqs_reg    <= sqs_next;
        srem_reg   <= srem_next;
        sroot_reg  <= sroot_next;
        len_reg    <= len_next;
        rnum_reg   <= rnum_next;
        rrem_reg   <= rrem_next;
        bf_reg     <= bf_next;
        f_reg      <= f_next;
        t_reg      <= t_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        m_data_reg <= m_data_next;
        m_slot_reg <= m_slot_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_slot_reg;
    assign m_tlast  = m_last_reg;

    // The end-of-cell flag marks exactly the last slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == csc_pkg::SLOT_LAST)))
        else $error("end-of-cell flag disagrees with slot");

    // The vector length is never below one, so the reciprocal fits 17 bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RECIP) |-> len_reg[16])
        else $error("vector length below one");

    // A finished vertex waits while the output register is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && m_valid_reg && !m_tready) |=> (state_reg == ST_OUT))
        else $error("vertex dropped under stall");

endmodule

`default_nettype wire
